### rtl/fixed_huffman_inflate_block_top_defines.svh
// Assertion macros used by the checker file of the inflate block.
`ifndef FIXED_HUFFMAN_INFLATE_BLOCK_TOP_DEFINES_SVH
`define FIXED_HUFFMAN_INFLATE_BLOCK_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define FHI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("inflate block check failed");

// Implication whose consequence is checked at the next clock edge.
`define FHI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("inflate block check failed");

`endif

### rtl/fhi_pkg.sv
package fhi_pkg;

    // History window depth used when the top level is not told otherwise.
    localparam int WINDOW_SIZE_DEF = 32768;

    // Reset value of the window limit register.
    localparam logic [15:0] WINDOW_LIMIT_RST = 16'h8000;

    // Decoder phases.
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_CODE       = 3'd1;
    localparam logic [2:0] PH_LEN_EXTRA  = 3'd2;
    localparam logic [2:0] PH_DIST_CODE  = 3'd3;
    localparam logic [2:0] PH_DIST_EXTRA = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SYM  = 2'd1;
    localparam logic [1:0] ST_BAD_DIST = 2'd2;
    localparam logic [1:0] ST_FAR_DIST = 2'd3;

    // Symbol boundaries.
    localparam logic [8:0] SYM_END      = 9'd256;
    localparam logic [8:0] SYM_LAST_LEN = 9'd285;

    // One result item as it leaves the decoder.
    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  byte_count;
        logic        last;
        logic        block_end;
        logic [1:0]  status;
    } res_t;

    function automatic logic [8:0] len_base(input logic [4:0] idx);
        logic [8:0] r;
        unique case (idx)
            5'd0: r = 9'd3;     5'd1: r = 9'd4;     5'd2: r = 9'd5;     5'd3: r = 9'd6;
            5'd4: r = 9'd7;     5'd5: r = 9'd8;     5'd6: r = 9'd9;     5'd7: r = 9'd10;
            5'd8: r = 9'd11;    5'd9: r = 9'd13;    5'd10: r = 9'd15;   5'd11: r = 9'd17;
            5'd12: r = 9'd19;   5'd13: r = 9'd23;   5'd14: r = 9'd27;   5'd15: r = 9'd31;
            5'd16: r = 9'd35;   5'd17: r = 9'd43;   5'd18: r = 9'd51;   5'd19: r = 9'd59;
            5'd20: r = 9'd67;   5'd21: r = 9'd83;   5'd22: r = 9'd99;   5'd23: r = 9'd115;
            5'd24: r = 9'd131;  5'd25: r = 9'd163;  5'd26: r = 9'd195;  5'd27: r = 9'd227;
            default: r = 9'd258;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] len_extra(input logic [4:0] idx);
        logic [3:0] r;
        if (idx < 5'd8 || idx > 5'd27)
        begin
            r = 4'd0;
        end
        else
        begin
            r = 4'((idx - 5'd4) >> 2);
        end
        return r;
    endfunction

    function automatic logic [15:0] dist_base(input logic [4:0] idx);
        logic [15:0] r;
        unique case (idx)
            5'd0: r = 16'd1;      5'd1: r = 16'd2;      5'd2: r = 16'd3;
            5'd3: r = 16'd4;      5'd4: r = 16'd5;      5'd5: r = 16'd7;
            5'd6: r = 16'd9;      5'd7: r = 16'd13;     5'd8: r = 16'd17;
            5'd9: r = 16'd25;     5'd10: r = 16'd33;    5'd11: r = 16'd49;
            5'd12: r = 16'd65;    5'd13: r = 16'd97;    5'd14: r = 16'd129;
            5'd15: r = 16'd193;   5'd16: r = 16'd257;   5'd17: r = 16'd385;
            5'd18: r = 16'd513;   5'd19: r = 16'd769;   5'd20: r = 16'd1025;
            5'd21: r = 16'd1537;  5'd22: r = 16'd2049;  5'd23: r = 16'd3073;
            5'd24: r = 16'd4097;  5'd25: r = 16'd6145;  5'd26: r = 16'd8193;
            5'd27: r = 16'd12289; 5'd28: r = 16'd16385; default: r = 16'd24577;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] dist_extra(input logic [4:0] idx);
        logic [3:0] r;
        if (idx < 5'd4)
        begin
            r = 4'd0;
        end
        else
        begin
            r = 4'((idx - 5'd2) >> 1);
        end
        return r;
    endfunction

endpackage

### rtl/fhi_if.sv
// Input channel: one compressed byte per item.
interface fhi_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       new_block;
    logic [2:0] start_bit_offset;

    modport source (output valid, data_byte, new_block, start_bit_offset, input ready);
    modport sink (input valid, data_byte, new_block, start_bit_offset, output ready);
endinterface

// Output channel: up to eight decoded bytes per item.
interface fhi_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last;
    logic        block_end;
    logic [1:0]  status;

    modport source (output valid, out_bytes, byte_count, last, block_end, status, input ready);
    modport sink (input valid, out_bytes, byte_count, last, block_end, status, output ready);
endinterface

### rtl/fixed_huffman_inflate_block_top.sv
// Fixed-Huffman deflate block decoder.
// in_ch takes one compressed byte per item, bits used least significant
// first; new_block starts a block body at start_bit_offset of that byte.
// out_ch gives items of up to eight decoded bytes, the first in the low
// byte; each input byte ends with an item marked last (possibly empty)
// that carries block_end and status.
// The decoder works on one byte at a time: in_ch.ready is low from
// acceptance until the last item of that byte has left the decoder.
// The bits are decoded in turn; a copy starts once its distance is
// complete and then writes its copied bytes, a full item of eight
// bytes going out before more are written, and the next byte is only
// accepted when the copy is done and the last item has left.
// Results pass through one output register; while out_ch is stalled the
// decoder holds its work once the next item is ready to leave.
// Reset clears the decoder to idle, marks the history empty and sets the
// window limit to 32768; the memory needs no clearing pass.
module fixed_huffman_inflate_block_top #(
    parameter int WINDOW_SIZE = fhi_pkg::WINDOW_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fhi_in_if.sink      in_ch,
    fhi_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int AW = $clog2(WINDOW_SIZE);

    logic [15:0]    window_limit_reg;
    logic           out_valid_reg;
    fhi_pkg::res_t  out_reg;
    logic           res_valid;
    logic           res_ready;
    fhi_pkg::res_t  res;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;

    // Window limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_limit_reg <= fhi_pkg::WINDOW_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            window_limit_reg <= cfg_wdata;
        end
    end

    // Output register: free when empty or being taken this cycle.
    assign res_ready = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_bytes  = out_reg.out_bytes;
    assign out_ch.byte_count = out_reg.byte_count;
    assign out_ch.last       = out_reg.last;
    assign out_ch.block_end  = out_reg.block_end;
    assign out_ch.status     = out_reg.status;

    fhi_ctrl #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_ready     (in_ch.ready),
        .in_byte      (in_ch.data_byte),
        .in_new_block (in_ch.new_block),
        .in_offset    (in_ch.start_bit_offset),
        .window_limit (window_limit_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    fhi_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

### rtl/fhi_ram.sv
module fhi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/fhi_ctrl.sv
module fhi_ctrl #(
    parameter int WINDOW_SIZE = fhi_pkg::WINDOW_SIZE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input item.
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     in_byte,
    input  logic                           in_new_block,
    input  logic [2:0]                     in_offset,
    input  logic [15:0]                    window_limit,
    // Result item towards the output register.
    output logic                           res_valid,
    input  logic                           res_ready,
    output fhi_pkg::res_t                  res,
    // History memory.
    output logic                           ram_we,
    output logic [$clog2(WINDOW_SIZE)-1:0] ram_waddr,
    output logic [7:0]                     ram_wdata,
    output logic [$clog2(WINDOW_SIZE)-1:0] ram_raddr,
    input  logic [7:0]                     ram_rdata
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int FW = $clog2(WINDOW_SIZE + 1);
    localparam logic [AW-1:0] WP_LAST = AW'(WINDOW_SIZE - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(WINDOW_SIZE);
    localparam logic [16:0] WS17 = 17'(WINDOW_SIZE);

    logic          busy_reg, busy_next;
    logic [7:0]    byte_reg, byte_next;
    logic [3:0]    pos_reg, pos_next;
    logic [2:0]    phase_reg, phase_next;
    logic [8:0]    cs_reg, cs_next;
    logic [3:0]    bits_reg, bits_next;
    logic [12:0]   extra_reg, extra_next;
    logic [8:0]    copy_len_reg, copy_len_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [63:0]   pack_reg, pack_next;
    logic [3:0]    pack_cnt_reg, pack_cnt_next;
    logic [1:0]    status_reg, status_next;
    logic          end_reg, end_next;
    logic          copy_act_reg, copy_act_next;
    logic [8:0]    issue_left_reg, issue_left_next;
    logic [8:0]    write_left_reg, write_left_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [AW-1:0] last_raddr_reg, last_raddr_next;
    logic          inflight_reg, inflight_next;
    logic          dist_one_reg, dist_one_next;
    logic [7:0]    last_byte_reg, last_byte_next;

    logic          bit_run;
    logic          cur_bit;
    logic          lit_we;
    logic [7:0]    lit_byte;
    logic          sym_valid;
    logic [8:0]    sym;
    logic          dist_valid;
    logic [15:0]   back_dist;
    logic          can_write;
    logic          cp_we;
    logic          hist_we;
    logic [7:0]    hist_byte;
    logic          flush_full;
    logic          emit_last;
    logic [8:0]    cs_shift;
    logic [12:0]   extra_or;
    logic [4:0]    sym_idx;
    logic [16:0]   rd_start;

    assign in_ready  = !busy_reg;
    assign cur_bit   = byte_reg[pos_reg[2:0]];
    assign can_write = (pack_cnt_reg != 4'd8);
    assign bit_run   = busy_reg && !copy_act_reg && (pos_reg != 4'd8)
                       && (phase_reg != fhi_pkg::PH_IDLE) && can_write;
    assign cp_we     = copy_act_reg && inflight_reg && can_write;
    assign hist_we   = lit_we || cp_we;
    assign hist_byte = lit_we ? lit_byte : (dist_one_reg ? last_byte_reg : ram_rdata);
    assign cs_shift  = {cs_reg[7:0], cur_bit};
    assign extra_or  = extra_reg | (13'(cur_bit) << bits_reg);
    assign sym_idx   = 5'(sym - 9'd257);
    assign rd_start  = ({1'b0, 16'(wp_reg)} >= {1'b0, back_dist})
                       ? (17'(wp_reg) - 17'(back_dist))
                       : (17'(wp_reg) + WS17 - 17'(back_dist));

    // Result hand-off: a full pack goes out first, then the closing item.
    assign flush_full = busy_reg && (pack_cnt_reg == 4'd8) && res_ready;
    assign emit_last  = busy_reg && !copy_act_reg && can_write && res_ready
                        && ((pos_reg == 4'd8) || (phase_reg == fhi_pkg::PH_IDLE));
    assign res_valid  = flush_full || emit_last;
    assign res.out_bytes  = pack_reg;
    assign res.byte_count = pack_cnt_reg;
    assign res.last       = emit_last;
    assign res.block_end  = emit_last && end_reg;
    assign res.status     = emit_last ? status_reg : fhi_pkg::ST_OK;

    // Memory port: history writes and copy reads.
    assign ram_we    = hist_we;
    assign ram_waddr = wp_reg;
    assign ram_wdata = hist_byte;

    // One stream bit per cycle unless stalled: prefix code, extra bits and distance code.
    always_comb
    begin
        phase_next    = phase_reg;
        cs_next       = cs_reg;
        bits_next     = bits_reg;
        extra_next    = extra_reg;
        copy_len_next = copy_len_reg;
        status_next   = status_reg;
        end_next      = end_reg;
        lit_we        = 1'b0;
        lit_byte      = 8'd0;
        sym_valid     = 1'b0;
        sym           = 9'd0;
        dist_valid    = 1'b0;
        back_dist     = 16'd0;
        if (bit_run)
        begin
            unique case (phase_reg)
                fhi_pkg::PH_CODE:
                begin
                    cs_next   = cs_shift;
                    bits_next = bits_reg + 4'd1;
                    if (bits_reg == 4'd6)
                    begin
                        if (cs_shift < 9'd24)
                        begin
                            sym_valid = 1'b1;
                            sym       = fhi_pkg::SYM_END + cs_shift;
                        end
                    end
                    else if (bits_reg == 4'd7)
                    begin
                        if (cs_shift >= 9'h030 && cs_shift <= 9'h0BF)
                        begin
                            sym_valid = 1'b1;
                            sym       = cs_shift - 9'h030;
                        end
                        else if (cs_shift >= 9'h0C0 && cs_shift <= 9'h0C7)
                        begin
                            sym_valid = 1'b1;
                            sym       = 9'd280 + cs_shift - 9'h0C0;
                        end
                    end
                    else if (bits_reg >= 4'd8)
                    begin
                        sym_valid = 1'b1;
                        if (cs_shift >= 9'h190)
                        begin
                            sym = 9'd144 + cs_shift - 9'h190;
                        end
                        else
                        begin
                            sym = 9'd511;
                        end
                    end
                end
                fhi_pkg::PH_LEN_EXTRA:
                begin
                    extra_next = extra_or;
                    bits_next  = bits_reg + 4'd1;
                    if (bits_next >= fhi_pkg::len_extra(cs_reg[4:0]))
                    begin
                        copy_len_next = fhi_pkg::len_base(cs_reg[4:0]) + extra_or[8:0];
                        cs_next       = 9'd0;
                        bits_next     = 4'd0;
                        extra_next    = 13'd0;
                        phase_next    = fhi_pkg::PH_DIST_CODE;
                    end
                end
                fhi_pkg::PH_DIST_CODE:
                begin
                    cs_next   = {4'd0, cs_shift[4:0]};
                    bits_next = bits_reg + 4'd1;
                    if (bits_next >= 4'd5)
                    begin
                        bits_next  = 4'd0;
                        extra_next = 13'd0;
                        if (cs_shift[4:0] > 5'd29)
                        begin
                            status_next = fhi_pkg::ST_BAD_DIST;
                            phase_next  = fhi_pkg::PH_IDLE;
                        end
                        else if (fhi_pkg::dist_extra(cs_shift[4:0]) == 4'd0)
                        begin
                            dist_valid = 1'b1;
                            back_dist  = fhi_pkg::dist_base(cs_shift[4:0]);
                        end
                        else
                        begin
                            phase_next = fhi_pkg::PH_DIST_EXTRA;
                        end
                    end
                end
                fhi_pkg::PH_DIST_EXTRA:
                begin
                    extra_next = extra_or;
                    bits_next  = bits_reg + 4'd1;
                    if (bits_next >= fhi_pkg::dist_extra(cs_reg[4:0]))
                    begin
                        dist_valid = 1'b1;
                        back_dist  = fhi_pkg::dist_base(cs_reg[4:0]) + 16'(extra_or);
                    end
                end
                default:
                begin
                    phase_next = fhi_pkg::PH_IDLE;
                end
            endcase

            // Symbol from the literal/length alphabet.
            if (sym_valid)
            begin
                if (sym < fhi_pkg::SYM_END)
                begin
                    lit_we     = 1'b1;
                    lit_byte   = sym[7:0];
                    phase_next = fhi_pkg::PH_CODE;
                    cs_next    = 9'd0;
                    bits_next  = 4'd0;
                    extra_next = 13'd0;
                end
                else if (sym == fhi_pkg::SYM_END)
                begin
                    end_next   = 1'b1;
                    phase_next = fhi_pkg::PH_IDLE;
                end
                else if (sym > fhi_pkg::SYM_LAST_LEN)
                begin
                    status_next = fhi_pkg::ST_BAD_SYM;
                    phase_next  = fhi_pkg::PH_IDLE;
                end
                else
                begin
                    bits_next  = 4'd0;
                    extra_next = 13'd0;
                    if (fhi_pkg::len_extra(sym_idx) == 4'd0)
                    begin
                        copy_len_next = fhi_pkg::len_base(sym_idx);
                        cs_next       = 9'd0;
                        phase_next    = fhi_pkg::PH_DIST_CODE;
                    end
                    else
                    begin
                        cs_next    = {4'd0, sym_idx};
                        phase_next = fhi_pkg::PH_LEN_EXTRA;
                    end
                end
            end

            // Distance complete: check it, then the copy takes over.
            if (dist_valid)
            begin
                if ({1'b0, back_dist} > 17'(fill_reg) || back_dist > window_limit)
                begin
                    status_next = fhi_pkg::ST_FAR_DIST;
                    phase_next  = fhi_pkg::PH_IDLE;
                end
                else
                begin
                    phase_next = fhi_pkg::PH_CODE;
                    cs_next    = 9'd0;
                    bits_next  = 4'd0;
                    extra_next = 13'd0;
                end
            end
        end

        // A new item resets per-item status; a new block restarts decoding.
        if (in_valid && in_ready)
        begin
            status_next = fhi_pkg::ST_OK;
            end_next    = 1'b0;
            if (in_new_block)
            begin
                phase_next    = fhi_pkg::PH_CODE;
                cs_next       = 9'd0;
                bits_next     = 4'd0;
                extra_next    = 13'd0;
                copy_len_next = 9'd0;
            end
        end
    end

    // Copy engine: one read issued and one byte written per cycle while the pack has room.
    always_comb
    begin
        copy_act_next   = copy_act_reg;
        issue_left_next = issue_left_reg;
        write_left_next = write_left_reg;
        rd_next         = rd_reg;
        last_raddr_next = last_raddr_reg;
        inflight_next   = 1'b0;
        dist_one_next   = dist_one_reg;
        ram_raddr       = rd_reg;
        if (copy_act_reg)
        begin
            if (inflight_reg && !can_write)
            begin
                // Stalled on a full pack: read the same entry again.
                ram_raddr     = last_raddr_reg;
                inflight_next = 1'b1;
            end
            else if (issue_left_reg != 9'd0)
            begin
                ram_raddr       = rd_reg;
                last_raddr_next = rd_reg;
                rd_next         = (rd_reg == WP_LAST) ? '0 : rd_reg + AW'(1);
                issue_left_next = issue_left_reg - 9'd1;
                inflight_next   = 1'b1;
            end
            if (cp_we)
            begin
                write_left_next = write_left_reg - 9'd1;
                if (write_left_reg == 9'd1)
                begin
                    copy_act_next = 1'b0;
                end
            end
        end
        else if (bit_run && dist_valid && phase_next == fhi_pkg::PH_CODE)
        begin
            copy_act_next   = 1'b1;
            rd_next         = AW'(rd_start);
            issue_left_next = copy_len_next;
            write_left_next = copy_len_next;
            dist_one_next   = (back_dist == 16'd1);
        end
    end

    // Item sequencing, pack assembly and history pointers.
    always_comb
    begin
        busy_next      = busy_reg;
        byte_next      = byte_reg;
        pos_next       = pos_reg;
        pack_next      = pack_reg;
        pack_cnt_next  = pack_cnt_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        last_byte_next = last_byte_reg;
        if (bit_run)
        begin
            pos_next = pos_reg + 4'd1;
        end
        if (hist_we)
        begin
            wp_next        = (wp_reg == WP_LAST) ? '0 : wp_reg + AW'(1);
            fill_next      = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + FW'(1);
            last_byte_next = hist_byte;
            pack_next[pack_cnt_reg[2:0]*8 +: 8] = hist_byte;
            pack_cnt_next  = pack_cnt_reg + 4'd1;
        end
        if (res_valid)
        begin
            pack_next     = 64'd0;
            pack_cnt_next = 4'd0;
        end
        if (emit_last)
        begin
            busy_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            busy_next = 1'b1;
            byte_next = in_byte;
            pos_next  = in_new_block ? {1'b0, in_offset} : 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pos_reg        <= 4'd0;
            phase_reg      <= fhi_pkg::PH_IDLE;
            cs_reg         <= 9'd0;
            bits_reg       <= 4'd0;
            extra_reg      <= 13'd0;
            copy_len_reg   <= 9'd0;
            wp_reg         <= '0;
            fill_reg       <= '0;
            pack_reg       <= 64'd0;
            pack_cnt_reg   <= 4'd0;
            status_reg     <= fhi_pkg::ST_OK;
            end_reg        <= 1'b0;
            copy_act_reg   <= 1'b0;
            issue_left_reg <= 9'd0;
            write_left_reg <= 9'd0;
            inflight_reg   <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            cs_reg         <= cs_next;
            bits_reg       <= bits_next;
            extra_reg      <= extra_next;
            copy_len_reg   <= copy_len_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            pack_reg       <= pack_next;
            pack_cnt_reg   <= pack_cnt_next;
            status_reg     <= status_next;
            end_reg        <= end_next;
            copy_act_reg   <= copy_act_next;
            issue_left_reg <= issue_left_next;
            write_left_reg <= write_left_next;
            inflight_reg   <= inflight_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        rd_reg         <= rd_next;
        last_raddr_reg <= last_raddr_next;
        dist_one_reg   <= dist_one_next;
        last_byte_reg  <= last_byte_next;
    end

endmodule

### rtl/fhi_checker.sv
`include "fixed_huffman_inflate_block_top_defines.svh"

module fhi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_bytes,
    input logic [3:0]  byte_count,
    input logic        last,
    input logic        block_end,
    input logic [1:0]  status
);

    // A stalled item keeps its bytes.
    `FHI_ASSERT_NEXT(a_hold, out_valid && !out_ready, $stable(out_bytes))

    // No item carries more than eight bytes.
    `FHI_ASSERT_IMP(a_count, out_valid, byte_count <= 4'd8)

    // Items before the last one of a byte are full and carry no status.
    `FHI_ASSERT_IMP(a_full, out_valid && !last, byte_count == 4'd8 && status == fhi_pkg::ST_OK && !block_end)

    // An error and an end of block never come together.
    `FHI_ASSERT_IMP(a_excl, out_valid && block_end, status == fhi_pkg::ST_OK)

endmodule

bind fixed_huffman_inflate_block_top fhi_checker u_fhi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_bytes  (out_ch.out_bytes),
    .byte_count (out_ch.byte_count),
    .last       (out_ch.last),
    .block_end  (out_ch.block_end),
    .status     (out_ch.status)
);
